### rtl/profile_sweep_vertex_generator_top_macros.svh
// assertion helpers for the vertex generator, clocked on clk, off during reset
`ifndef PROFILE_SWEEP_VERTEX_GENERATOR_TOP_MACROS_SVH
`define PROFILE_SWEEP_VERTEX_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define PVG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvg_pkg;

  localparam int COORD_W  = 32;
  localparam int IDX_W    = 18;
  localparam int SLC_W    = 7;
  localparam int PTS_W    = 13;
  localparam int PHASE_W  = 32;
  localparam int CFG_W    = 32;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int AB_W         = 34;
  localparam int ANG_W        = 33;
  localparam int FRAC_W       = 30;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int SUM_W        = PROD_W + 1;

  localparam logic signed [AB_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
    33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
    33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81,       33'sd41,
    33'sd20,        33'sd10,        33'sd5,         33'sd3,        33'sd1
  };

  // configuration port
  typedef logic [1:0]       cfg_idx_t;
  typedef logic [CFG_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_SLICES = 2'd0;
  localparam cfg_idx_t REG_POINTS = 2'd1;
  localparam cfg_idx_t REG_ANGLE  = 2'd2;

  localparam logic [SLC_W-1:0]   SLICES_RST = 7'd16;
  localparam logic [PTS_W-1:0]   POINTS_RST = 13'd16;
  localparam logic [PHASE_W-1:0] ANGLE_RST  = 32'h1000_0000;

  localparam logic [SLC_W-1:0] MIN_SLICES = 7'd3;
  localparam logic [PTS_W-1:0] MIN_POINTS = 13'd3;

  typedef enum logic {
    KIND_PASS,
    KIND_RING
  } kind_t;

  // one classified point waiting for the back end
  typedef struct packed {
    kind_t                     kind;
    logic [IDX_W-1:0]          idx;
    logic [PTS_W-1:0]          step;
    logic [SLC_W-1:0]          count;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } entry_t;

  // one vertex launched into the rotator
  typedef struct packed {
    logic                      valid;
    logic                      pass;
    logic                      last;
    logic [IDX_W-1:0]          idx;
    logic [PHASE_W-1:0]        phase;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } issue_t;

  // sideband carried along the rotator stages
  typedef struct packed {
    logic                      pass;
    logic                      last;
    logic                      neg;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } side_t;

endpackage

`default_nettype wire

### rtl/pvg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pvg_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pvg_pkg::COORD_W-1:0] px;
  logic signed [pvg_pkg::COORD_W-1:0] py;
  logic signed [pvg_pkg::COORD_W-1:0] pz;

  modport source (output valid, output px, output py, output pz, input ready);
  modport sink (input valid, input px, input py, input pz, output ready);
endinterface

`default_nettype wire

### rtl/pvg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pvg_out_if;
  logic                               valid;
  logic                               ready;
  logic [pvg_pkg::IDX_W-1:0]          vertex_index;
  logic signed [pvg_pkg::COORD_W-1:0] vx;
  logic signed [pvg_pkg::COORD_W-1:0] vy;
  logic signed [pvg_pkg::COORD_W-1:0] vz;
  logic                               last_of_run;

  modport source (output valid, output vertex_index, output vx, output vy, output vz,
                  output last_of_run, input ready);
  modport sink (input valid, input vertex_index, input vx, input vy, input vz,
                input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/pvg_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pvg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pvg_pkg::entry_t wr_entry,
  input  logic            pop,
  output logic            rd_valid,
  output pvg_pkg::entry_t rd_entry,
  output logic            full
);
  import pvg_pkg::*;

  // power of two, pointers wrap on their own
  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  entry_t         mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pvg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pvg_front #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_SLICES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pvg_in_if.sink                      in_pt,
  input  logic [pvg_pkg::SLC_W-1:0]   cfg_slices,
  input  logic [pvg_pkg::PTS_W-1:0]   cfg_points,
  input  logic                        q_full,
  output logic                        q_push,
  output pvg_pkg::entry_t             q_entry
);
  import pvg_pkg::*;

  localparam int PTS_MAX = (1 << PTS_W) - 1;
  localparam int PCAP    = (MAX_POINTS < PTS_MAX) ? MAX_POINTS : PTS_MAX;
  localparam int PW      = $clog2(PCAP);
  localparam int MW      = PTS_W + SLC_W;

  logic [PW-1:0]    pt_cnt_r;
  logic [PW-1:0]    pt_cnt_nxt;
  logic [SLC_W-1:0] s_cl;
  logic [PTS_W-1:0] p_cl;
  logic [PTS_W-1:0] ring;
  logic             is_bottom;
  logic             is_top;
  logic [MW-1:0]    cap_prod;
  logic [IDX_W-1:0] cap_idx;

  always_comb begin
    if (cfg_slices < MIN_SLICES) begin
      s_cl = MIN_SLICES;
    end else if (cfg_slices > SLC_W'(MAX_SLICES)) begin
      s_cl = SLC_W'(MAX_SLICES);
    end else begin
      s_cl = cfg_slices;
    end
  end

  always_comb begin
    if (cfg_points < MIN_POINTS) begin
      p_cl = MIN_POINTS;
    end else if (cfg_points > PTS_W'(PCAP)) begin
      p_cl = PTS_W'(PCAP);
    end else begin
      p_cl = cfg_points;
    end
  end

  assign ring      = p_cl - PTS_W'(2);
  assign is_bottom = (pt_cnt_r == '0);
  // a counter left beyond the end by a config change counts as the top
  assign is_top    = !is_bottom && (PTS_W'(pt_cnt_r) >= p_cl - PTS_W'(1));
  assign cap_prod  = MW'(ring) * MW'(s_cl);
  assign cap_idx   = cap_prod[IDX_W-1:0] + (is_bottom ? IDX_W'(1) : IDX_W'(0));

  always_comb begin
    if (is_bottom) begin
      pt_cnt_nxt = PW'(1);
    end else if (is_top) begin
      pt_cnt_nxt = '0;
    end else begin
      pt_cnt_nxt = pt_cnt_r + PW'(1);
    end
  end

  assign in_pt.ready = !q_full;
  assign q_push      = in_pt.valid && !q_full;

  always_comb begin
    q_entry.kind  = (is_bottom || is_top) ? KIND_PASS : KIND_RING;
    q_entry.idx   = (is_bottom || is_top) ? cap_idx : IDX_W'(pt_cnt_r) - IDX_W'(1);
    q_entry.step  = ring;
    q_entry.count = s_cl;
    q_entry.x     = in_pt.px;
    q_entry.y     = in_pt.py;
    q_entry.z     = in_pt.pz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_cnt_r <= '0;
    end else if (q_push) begin
      pt_cnt_r <= pt_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pvg_issue.sv
`timescale 1ns / 1ps
`default_nettype none

module pvg_issue #(
  parameter int MAX_SLICES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  pvg_pkg::entry_t             q_head,
  input  logic [pvg_pkg::PHASE_W-1:0] angle_step,
  input  logic                        adv,
  output logic                        q_pop,
  output pvg_pkg::issue_t             iss
);
  import pvg_pkg::*;

  localparam int JW = $clog2(MAX_SLICES);

  logic [JW-1:0]      j_r;
  logic [JW-1:0]      j_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [IDX_W-1:0]   off_r;
  logic [IDX_W-1:0]   off_nxt;
  logic               is_pass;
  logic               is_last;
  logic               fire;

  assign is_pass = (q_head.kind == KIND_PASS);
  assign is_last = is_pass || ((SLC_W'(j_r) + SLC_W'(1)) == q_head.count);
  assign fire    = q_valid && adv;
  assign q_pop   = fire && is_last;

  always_comb begin
    iss.valid = q_valid;
    iss.pass  = is_pass;
    iss.last  = is_last;
    iss.idx   = q_head.idx + off_r;
    iss.phase = phase_r;
    iss.x     = q_head.x;
    iss.y     = q_head.y;
    iss.z     = q_head.z;
  end

  // slice, phase and index offset step together; all back to zero after a run
  always_comb begin
    j_nxt     = j_r;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    if (fire && is_last) begin
      j_nxt     = '0;
      phase_nxt = '0;
      off_nxt   = '0;
    end else if (fire) begin
      j_nxt     = j_r + JW'(1);
      phase_nxt = phase_r + angle_step;
      off_nxt   = off_r + IDX_W'(q_head.step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r     <= '0;
      phase_r <= '0;
      off_r   <= '0;
    end else begin
      j_r     <= j_nxt;
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pvg_rotator.sv
`timescale 1ns / 1ps
`default_nettype none

module pvg_rotator (
  input  logic            clk,
  input  logic            rst_n,
  input  pvg_pkg::issue_t iss,
  output logic            adv,
  pvg_out_if.source       out_vtx
);
  import pvg_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam int QW = SUM_W - FRAC_W;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [QW-1:0]    SAT_HI     = QW'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [QW-1:0]    SAT_LO     = -SAT_HI - QW'(1);

  function automatic logic [COORD_W-1:0] round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] biased;
    logic signed [QW-1:0]    q;
    biased = sum + ROUND_BIAS;
    q      = biased[SUM_W-1:FRAC_W];
    if (q > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (q < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end
    return q[COORD_W-1:0];
  endfunction

  // cordic stages
  logic                   v_r  [NS+1];
  side_t                  sd_r [NS+1];
  logic signed [AB_W-1:0] a_r  [NS+1];
  logic signed [AB_W-1:0] b_r  [NS+1];
  ang_t                   g_r  [NS+1];

  logic [1:0]         quad;
  logic               fold;
  logic [PHASE_W-1:0] ph_fold;

  // fold the two middle quadrants by a half turn, undone by negation later
  assign quad    = iss.phase[PHASE_W-1 -: 2];
  assign fold    = (quad == 2'b01) || (quad == 2'b10);
  assign ph_fold = {iss.phase[PHASE_W-1] ^ fold, iss.phase[PHASE_W-2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= iss.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0].pass <= iss.pass;
      sd_r[0].last <= iss.last;
      sd_r[0].neg  <= fold;
      sd_r[0].idx  <= iss.idx;
      sd_r[0].x    <= iss.x;
      sd_r[0].y    <= iss.y;
      sd_r[0].z    <= iss.z;
      a_r[0]       <= CORDIC_GAIN;
      b_r[0]       <= '0;
      g_r[0]       <= ANG_W'($signed(ph_fold));
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [AB_W-1:0] da;
    logic signed [AB_W-1:0] db;

    assign da = b_r[i] >>> i;
    assign db = a_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[i+1] <= sd_r[i];
        if (!g_r[i][ANG_W-1]) begin
          a_r[i+1] <= a_r[i] - da;
          b_r[i+1] <= b_r[i] + db;
          g_r[i+1] <= g_r[i] - ATAN_TAB[i];
        end else begin
          a_r[i+1] <= a_r[i] + da;
          b_r[i+1] <= b_r[i] - db;
          g_r[i+1] <= g_r[i] + ATAN_TAB[i];
        end
      end
    end
  end

  // negate and narrow to q2.30
  logic                      vn_r;
  side_t                     sdn_r;
  logic signed [COORD_W-1:0] c_r;
  logic signed [COORD_W-1:0] s_r;
  logic signed [AB_W-1:0]    a_fix;
  logic signed [AB_W-1:0]    b_fix;

  assign a_fix = sd_r[NS].neg ? -a_r[NS] : a_r[NS];
  assign b_fix = sd_r[NS].neg ? -b_r[NS] : b_r[NS];

  // products
  logic                     vm1_r;
  side_t                    sdm1_r;
  logic signed [PROD_W-1:0] pxc_r;
  logic signed [PROD_W-1:0] pzs_r;
  logic signed [PROD_W-1:0] pzc_r;
  logic signed [PROD_W-1:0] pxs_r;

  // sums
  logic                    vm2_r;
  side_t                   sdm2_r;
  logic signed [SUM_W-1:0] sx_r;
  logic signed [SUM_W-1:0] sz_r;

  // output register
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic signed [COORD_W-1:0] out_z_r;
  logic                      out_last_r;

  // whole pipe moves together, held while the output word is stuck
  assign adv = !out_valid_r || out_vtx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r        <= 1'b0;
      vm1_r       <= 1'b0;
      vm2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vn_r        <= v_r[NS];
      vm1_r       <= vn_r;
      vm2_r       <= vm1_r;
      out_valid_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdn_r      <= sd_r[NS];
      c_r        <= a_fix[COORD_W-1:0];
      s_r        <= b_fix[COORD_W-1:0];

      sdm1_r     <= sdn_r;
      pxc_r      <= PROD_W'(sdn_r.x) * PROD_W'(c_r);
      pzs_r      <= PROD_W'(sdn_r.z) * PROD_W'(s_r);
      pzc_r      <= PROD_W'(sdn_r.z) * PROD_W'(c_r);
      pxs_r      <= PROD_W'(sdn_r.x) * PROD_W'(s_r);

      sdm2_r     <= sdm1_r;
      sx_r       <= SUM_W'(pxc_r) + SUM_W'(pzs_r);
      sz_r       <= SUM_W'(pzc_r) - SUM_W'(pxs_r);

      out_idx_r  <= sdm2_r.idx;
      out_x_r    <= sdm2_r.pass ? sdm2_r.x : round_sat(sx_r);
      out_y_r    <= sdm2_r.y;
      out_z_r    <= sdm2_r.pass ? sdm2_r.z : round_sat(sz_r);
      out_last_r <= sdm2_r.last;
    end
  end

  assign out_vtx.valid        = out_valid_r;
  assign out_vtx.vertex_index = out_idx_r;
  assign out_vtx.vx           = out_x_r;
  assign out_vtx.vy           = out_y_r;
  assign out_vtx.vz           = out_z_r;
  assign out_vtx.last_of_run  = out_last_r;

endmodule

`default_nettype wire

### rtl/profile_sweep_vertex_generator_top.sv
// channel   dir  word                                   accepted when
// in_pt     in   px, py, pz                             valid && ready
// out_vtx   out  vertex_index, vx, vy, vz, last_of_run  valid && ready
// cfg       in   cfg_index, cfg_data                    cfg_we
//
// interior point: a vertex per slice, one per cycle from the sequencer unless stalled
// bottom and top points: a single vertex, passed through the same pipe to keep order
// rotator stages in order: fold, 30 cordic steps, negate, multiply, add, round
// reset is synchronous, clears counters and valid bits, loads config defaults
// a stalled output freezes the whole rotator; the 2-word queue takes input till full
`timescale 1ns / 1ps
`default_nettype none
`include "profile_sweep_vertex_generator_top_macros.svh"

module profile_sweep_vertex_generator_top #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_SLICES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  pvg_in_if.sink              in_pt,
  pvg_out_if.source           out_vtx,
  input  logic                cfg_we,
  input  pvg_pkg::cfg_idx_t   cfg_index,
  input  pvg_pkg::cfg_data_t  cfg_data
);
  import pvg_pkg::*;

  // config registers
  logic [SLC_W-1:0]   slices_r;
  logic [PTS_W-1:0]   points_r;
  logic [PHASE_W-1:0] angle_r;

  // front to back queue
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  logic   q_full;
  entry_t q_entry;
  entry_t q_head;

  // sequencer to rotator
  issue_t iss;
  logic   adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= SLICES_RST;
      points_r <= POINTS_RST;
      angle_r  <= ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICES: slices_r <= cfg_data[SLC_W-1:0];
        REG_POINTS: points_r <= cfg_data[PTS_W-1:0];
        REG_ANGLE:  angle_r  <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // classify points, track position in the profile
  pvg_front #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_SLICES (MAX_SLICES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pt      (in_pt),
    .cfg_slices (slices_r),
    .cfg_points (points_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  pvg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_head),
    .full     (q_full)
  );

  // walk the slices of the head word
  pvg_issue #(
    .MAX_SLICES (MAX_SLICES)
  ) u_issue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .angle_step (angle_r),
    .adv        (adv),
    .q_pop      (q_pop),
    .iss        (iss)
  );

  // sin/cos, rotation and the output register
  pvg_rotator u_rotator (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .adv     (adv),
    .out_vtx (out_vtx)
  );

  `PVG_ASSERT_IMPL(a_stall_holds_queue, out_vtx.valid && !out_vtx.ready, !q_pop, "queue popped while output stalled")
  `PVG_ASSERT_IMPL(a_pop_at_run_end, q_pop, q_valid && iss.last, "queue popped before the end of a slice run")
  `PVG_ASSERT_NEXT(a_stall_freezes_issue, out_vtx.valid && !out_vtx.ready && q_valid, q_valid && $stable(iss.idx) && $stable(iss.phase), "issue moved while output stalled")

endmodule

`default_nettype wire
